[sv/sgf_pkg.sv]
// ----------------------------------------------------------------------------
// sgf_pkg
// shared types and constants of the smoothed gain follower
// ----------------------------------------------------------------------------
package sgf_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  localparam int STEP_W    = 3;
  localparam int CNT_W     = 4;
  localparam int NUM_STEPS = 8;

  localparam logic [STEP_W-1:0] STEP_AMP_ENERGY = 3'd0;
  localparam logic [STEP_W-1:0] STEP_AMP_CALM   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TMP_TEMPO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TMP_ENERGY = 3'd3;
  localparam logic [STEP_W-1:0] STEP_AMP_LEVEL  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_TMP_LEVEL  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_AMP_GAIN   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_TMP_GAIN   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

endpackage

[sv/sgf_if.sv]
// ----------------------------------------------------------------------------
// sgf_if
// valid/ready channels of the smoothed gain follower
// ----------------------------------------------------------------------------
interface sgf_in_if #(
  parameter int FRAC_BITS = 14
);
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [FRAC_BITS:0] influence;
  logic [FRAC_BITS:0] energy;
  logic [FRAC_BITS:0] calm;
  logic [FRAC_BITS:0] tempo;
  logic [FRAC_BITS:0] consent;

  modport source (output valid, cmd, influence, energy, calm, tempo, consent, input ready);
  modport sink   (input valid, cmd, influence, energy, calm, tempo, consent, output ready);
endinterface

interface sgf_out_if #(
  parameter int FRAC_BITS = 14
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] amp_gain;
  logic [FRAC_BITS:0] tempo_gain;

  modport source (output valid, amp_gain, tempo_gain, input ready);
  modport sink   (input valid, amp_gain, tempo_gain, output ready);
endinterface

[sv/smoothed_gain_follower_top.sv]
// ----------------------------------------------------------------------------
// smoothed_gain_follower_top
// smoothed amplitude and tempo gains from five Q1.F control inputs
// ----------------------------------------------------------------------------
// Input items arrive on in_i and are taken when valid and ready are both
// high; each produces exactly one gain pair on out_o, in order.
// The front classifies an item in the transfer cycle and writes it to a
// two-entry queue; ready is low only while that queue is full.
// The back runs an update item through eight products on one shared
// multiplier and takes no new item until the last product has retired
// and its gains are loaded into the output register. A reset item, or one
// that is inactive, loads unity gains and levels when the back starts it,
// without running the products.
// The result waits in an output register while out_o ready is low; the
// back holds its next item and the queue keeps accepting until full.
// Configuration is a plain write port: index 0 softness (saturated to
// 0.1..0.9), index 1 enabled; writing enabled as 0 returns both levels to 1.0.
// After reset the levels are 1.0, softness is 0.5, the block is disabled
// and the queue and output register are empty.
// ----------------------------------------------------------------------------
module smoothed_gain_follower_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sgf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FRAC_BITS-1:0]          cfg_wdata_i,
  sgf_in_if.sink                        in_i,
  sgf_out_if.source                     out_o
);

  localparam int W   = FRAC_BITS + 1;
  localparam int DW  = 1 + 4 * W;
  localparam int K01 = (((1 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K05 = (((5 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K08 = (((8 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K09 = (((9 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K12 = (((12 << (FRAC_BITS + 1)) / 10) + 1) >> 1;

  logic [FRAC_BITS-1:0] softness_q, softness_d;
  logic                 enabled_q;
  logic                 lvl_clr;
  logic                 q_push;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic [DW-1:0]        q_in_item;
  logic [DW-1:0]        q_out_item;

  always_comb begin
    softness_d = cfg_wdata_i;
    if (cfg_wdata_i < FRAC_BITS'(K01)) softness_d = FRAC_BITS'(K01);
    if (cfg_wdata_i > FRAC_BITS'(K09)) softness_d = FRAC_BITS'(K09);
  end

  assign lvl_clr = cfg_we_i && (cfg_idx_i == sgf_pkg::CFG_ENABLED) && !cfg_wdata_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      softness_q <= FRAC_BITS'(K05);
      enabled_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgf_pkg::CFG_SOFTNESS: softness_q <= softness_d;
        sgf_pkg::CFG_ENABLED:  enabled_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  sgf_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_i      (in_i),
    .enabled_i (enabled_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (q_in_item)
  );

  sgf_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out_item),
    .pop_i   (q_pop)
  );

  sgf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .softness_i (softness_q),
    .lvl_clr_i  (lvl_clr),
    .q_valid_i  (q_valid),
    .q_item_i   (q_out_item),
    .q_pop_o    (q_pop),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  a_amp_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.amp_gain >= W'(K05)) && (out_o.amp_gain <= W'(K12)))
    else $error("amplitude gain out of range");

  a_tempo_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.tempo_gain >= W'(K08)) && (out_o.tempo_gain <= W'(K12)))
    else $error("tempo gain out of range");

  a_softness_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == sgf_pkg::CFG_SOFTNESS)) |=>
      (softness_q >= FRAC_BITS'(K01)) && (softness_q <= FRAC_BITS'(K09)))
    else $error("softness not saturated");
`endif

endmodule

[sv/sgf_front.sv]
// ----------------------------------------------------------------------------
// sgf_front
// accepts input items, saturates the fields and marks level resets
// ----------------------------------------------------------------------------
module sgf_front #(
  parameter int FRAC_BITS = 14,
  localparam int W  = FRAC_BITS + 1,
  localparam int DW = 1 + 4 * W
) (
  sgf_in_if.sink        in_i,
  input  logic          enabled_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output logic [DW-1:0] q_item_o
);

  localparam int ONE = 1 << FRAC_BITS;
  localparam int K03 = (((3 << (FRAC_BITS + 1)) / 10) + 1) >> 1;

  logic [W-1:0] inf_sat;
  logic [W-1:0] eng_sat;
  logic [W-1:0] calm_sat;
  logic [W-1:0] tmp_sat;
  logic         is_reset;

  assign inf_sat  = (in_i.influence > W'(ONE)) ? W'(ONE) : in_i.influence;
  assign eng_sat  = (in_i.energy    > W'(ONE)) ? W'(ONE) : in_i.energy;
  assign calm_sat = (in_i.calm      > W'(ONE)) ? W'(ONE) : in_i.calm;
  assign tmp_sat  = (in_i.tempo     > W'(ONE)) ? W'(ONE) : in_i.tempo;

  // consent threshold sits below one, so the raw value compares the same
  assign is_reset = in_i.cmd || !enabled_i || (in_i.consent < W'(K03)) ||
                    (inf_sat == '0);

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;
  assign q_item_o   = {is_reset, inf_sat, eng_sat, calm_sat, tmp_sat};

endmodule

[sv/sgf_queue.sv]
// ----------------------------------------------------------------------------
// sgf_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module sgf_queue #(
  parameter int DW = 61
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] item_i,
  output logic          full_o,
  output logic          valid_o,
  output logic [DW-1:0] item_o,
  input  logic          pop_i
);

  localparam int DEPTH = sgf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[sv/sgf_back.sv]
// ----------------------------------------------------------------------------
// sgf_back
// smoothing sequencer on one shared rounding multiplier
// ----------------------------------------------------------------------------
module sgf_back #(
  parameter int FRAC_BITS = 14,
  localparam int W  = FRAC_BITS + 1,
  localparam int DW = 1 + 4 * W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [FRAC_BITS-1:0] softness_i,
  input  logic                 lvl_clr_i,
  input  logic                 q_valid_i,
  input  logic [DW-1:0]        q_item_i,
  output logic                 q_pop_o,
  sgf_out_if.source            out_o
);

  localparam int SW = FRAC_BITS + 4;
  localparam int MW = FRAC_BITS + 3;
  localparam int PW = 2 * MW;

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int K02  = (((2 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K03  = (((3 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K04  = (((4 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K05  = (((5 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K06  = (((6 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K08  = (((8 << (FRAC_BITS + 1)) / 10) + 1) >> 1;
  localparam int K12  = (((12 << (FRAC_BITS + 1)) / 10) + 1) >> 1;

  localparam logic signed [SW-1:0] C_ONE = SW'(ONE);
  localparam logic signed [SW-1:0] C_K05 = SW'(K05);
  localparam logic signed [SW-1:0] C_K08 = SW'(K08);
  localparam logic signed [SW-1:0] C_K12 = SW'(K12);
  localparam logic signed [PW-1:0] C_RND_POS = PW'(HALF);
  localparam logic signed [PW-1:0] C_RND_NEG = PW'(HALF - 1);

  function automatic logic signed [SW-1:0] clamp_s(input logic signed [SW-1:0] v,
                                                    input logic signed [SW-1:0] lo,
                                                    input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  sgf_pkg::back_state_e state_q;

  logic [sgf_pkg::CNT_W-1:0]  cnt_q;
  logic [sgf_pkg::STEP_W-1:0] step;
  logic [sgf_pkg::STEP_W-1:0] tag;
  logic                       out_valid_q;
  logic                       out_load;
  logic                       start;
  logic                       item_rst;
  logic                       issue;
  logic                       retire;

  logic [W-1:0] inf_q, eng_q, calm_q, tmp_q;
  logic [W-1:0] amp_gain_q, tmp_gain_q;

  logic signed [SW-1:0] amp_lvl_q, tmp_lvl_q;
  logic signed [SW-1:0] amp_t_q, tmp_t_q;
  logic signed [SW-1:0] inf_s, eng_s, calm_s, tmp_s, soft_s;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [PW-1:0] rsum, rsh;
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] amp_lvl_upd, tmp_lvl_upd, amp_gain_upd, tmp_gain_upd;

  assign item_rst = q_item_i[DW-1];
  assign start    = (state_q == sgf_pkg::ST_IDLE) && q_valid_i &&
                    (!out_valid_q || out_o.ready);
  assign q_pop_o  = start;

  assign step   = cnt_q[sgf_pkg::STEP_W-1:0];
  assign tag    = sgf_pkg::STEP_W'(cnt_q - 1'b1);
  assign issue  = (state_q == sgf_pkg::ST_RUN) && (cnt_q != sgf_pkg::CNT_W'(sgf_pkg::NUM_STEPS));
  assign retire = (state_q == sgf_pkg::ST_RUN) && (cnt_q != '0);

  assign out_load = (start && item_rst) || ((state_q == sgf_pkg::ST_RUN) && !issue);

  assign inf_s  = signed'(SW'(inf_q));
  assign eng_s  = signed'(SW'(eng_q));
  assign calm_s = signed'(SW'(calm_q));
  assign tmp_s  = signed'(SW'(tmp_q));
  assign soft_s = signed'(SW'(softness_i));

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      sgf_pkg::STEP_AMP_ENERGY: begin
        op_a = MW'(eng_s - C_K05);
        op_b = MW'(K06);
      end
      sgf_pkg::STEP_AMP_CALM: begin
        op_a = MW'(calm_s - C_K05);
        op_b = MW'(K04);
      end
      sgf_pkg::STEP_TMP_TEMPO: begin
        op_a = MW'(tmp_s - C_K05);
        op_b = MW'(K03);
      end
      sgf_pkg::STEP_TMP_ENERGY: begin
        op_a = MW'(eng_s - C_K05);
        op_b = MW'(K02);
      end
      sgf_pkg::STEP_AMP_LEVEL: begin
        op_a = MW'(soft_s);
        op_b = MW'(amp_t_q - amp_lvl_q);
      end
      sgf_pkg::STEP_TMP_LEVEL: begin
        op_a = MW'(soft_s);
        op_b = MW'(tmp_t_q - tmp_lvl_q);
      end
      sgf_pkg::STEP_AMP_GAIN: begin
        op_a = MW'(amp_lvl_q - C_ONE);
        op_b = MW'(inf_s);
      end
      sgf_pkg::STEP_TMP_GAIN: begin
        op_a = MW'(tmp_lvl_q - C_ONE);
        op_b = MW'(inf_s);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  // round half away from zero on the registered product
  assign rsum = prod_q + (prod_q[PW-1] ? C_RND_NEG : C_RND_POS);
  assign rsh  = rsum >>> FRAC_BITS;
  assign rnd  = signed'(rsh[SW-1:0]);

  assign amp_lvl_upd  = clamp_s(amp_lvl_q + rnd, C_K05, C_K12);
  assign tmp_lvl_upd  = clamp_s(tmp_lvl_q + rnd, C_K08, C_K12);
  assign amp_gain_upd = clamp_s(C_ONE + rnd, C_K05, C_K12);
  assign tmp_gain_upd = clamp_s(C_ONE + rnd, C_K08, C_K12);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgf_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      amp_lvl_q   <= C_ONE;
      tmp_lvl_q   <= C_ONE;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (lvl_clr_i) begin
        amp_lvl_q <= C_ONE;
        tmp_lvl_q <= C_ONE;
      end
      case (state_q)
        sgf_pkg::ST_IDLE: begin
          if (start) begin
            if (item_rst) begin
              amp_lvl_q <= C_ONE;
              tmp_lvl_q <= C_ONE;
            end else begin
              state_q <= sgf_pkg::ST_RUN;
              cnt_q   <= '0;
            end
          end
        end
        sgf_pkg::ST_RUN: begin
          if (retire && (tag == sgf_pkg::STEP_AMP_LEVEL)) begin
            amp_lvl_q <= amp_lvl_upd;
          end
          if (retire && (tag == sgf_pkg::STEP_TMP_LEVEL)) begin
            tmp_lvl_q <= tmp_lvl_upd;
          end
          if (!issue) begin
            state_q <= sgf_pkg::ST_IDLE;
          end
          cnt_q <= sgf_pkg::CNT_W'(cnt_q + 1'b1);
        end
        default: begin
          state_q <= sgf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      inf_q  <= q_item_i[4*W-1:3*W];
      eng_q  <= q_item_i[3*W-1:2*W];
      calm_q <= q_item_i[2*W-1:W];
      tmp_q  <= q_item_i[W-1:0];
      if (item_rst) begin
        amp_gain_q <= W'(ONE);
        tmp_gain_q <= W'(ONE);
      end
    end
    if (issue) begin
      prod_q <= prod_d;
    end
    if (retire) begin
      case (tag)
        sgf_pkg::STEP_AMP_ENERGY: amp_t_q    <= C_ONE + rnd;
        sgf_pkg::STEP_AMP_CALM:   amp_t_q    <= amp_t_q - rnd;
        sgf_pkg::STEP_TMP_TEMPO:  tmp_t_q    <= C_ONE + rnd;
        sgf_pkg::STEP_TMP_ENERGY: tmp_t_q    <= tmp_t_q - rnd;
        sgf_pkg::STEP_AMP_GAIN:   amp_gain_q <= amp_gain_upd[W-1:0];
        sgf_pkg::STEP_TMP_GAIN:   tmp_gain_q <= tmp_gain_upd[W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.amp_gain   = amp_gain_q;
  assign out_o.tempo_gain = tmp_gain_q;

endmodule
